### src/rat_pkg.sv
// ----------------------------------------------------------------------------
// Region address translator package
// Shared types, sizes and codes for the region address translator.
// ----------------------------------------------------------------------------
package rat_pkg;

   localparam int MAX_REGIONS = 8;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   // Queue depth must stay a power of two so the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_ADD       = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_WRAPS     = 3'd2;
   localparam logic [2:0] ST_OVERLAP   = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic        command;
      logic [31:0] address;
      logic [31:0] region_length;
      logic [31:0] host_base;
      logic [3:0]  new_type;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] host_address;
      logic [3:0]  found_type;
   } rsp_type;

   // Item after classification: end of range and host delta precomputed.
   typedef struct packed {
      logic        command;
      logic [31:0] address;
      logic [32:0] new_end;
      logic [31:0] host_delta;
      logic [3:0]  new_type;
   } cls_type;

endpackage

### src/region_address_translator.sv
// An accepted item is registered in the front queue; the back end then registers its result
// in the result queue, where rsp_data shows it until it is popped.
// One item per cycle while the result queue has room; rat_back has one lookup stage.
// Each side has a two-item queue, so a stalled result side fills at most four items.
// Reset: clears the region count and both queues; table words are left as they are
// and only entries below the count are ever consulted.
// ----------------------------------------------------------------------------
// Region address translator
// Base/limit region table with add and translate commands, queue interfaces.
// ----------------------------------------------------------------------------
module region_address_translator
   import rat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // Front to back: classified item queue head and its pop.
   logic    fq_empty;
   logic    fq_pop;
   cls_type fq_item;

   // Front: accept the item, compute the range end and the host delta, queue it.
   rat_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .fq_empty (fq_empty),
      .fq_item  (fq_item),
      .fq_pop   (fq_pop)
   );

   // Back: look up the table, append on a clean add, queue the result item.
   // Advance only while the result queue has room.
   rat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fq_empty  (fq_empty),
      .fq_item   (fq_item),
      .fq_pop    (fq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Any result other than a translate hit carries zero address and type.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_OK) |->
         (rsp_data.host_address == '0 && rsp_data.found_type == '0))
      else $error("non-hit result carries payload");

   // Never draw from an empty front queue.
   assert property (@(posedge clock) disable iff (reset)
      fq_pop |-> !fq_empty)
      else $error("pop from empty front queue");

   // Both queues come out of reset empty.
   assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full && fq_empty))
      else $error("queues not empty after reset");

   // Status codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.status == ST_OK || rsp_data.status == ST_FULL ||
                      rsp_data.status == ST_WRAPS || rsp_data.status == ST_OVERLAP ||
                      rsp_data.status == ST_NOT_FOUND))
      else $error("undefined status code");

endmodule

### src/rat_front.sv
// ----------------------------------------------------------------------------
// Region address translator front end
// Accepts items, precomputes range end and host delta, queues them.
// ----------------------------------------------------------------------------
module rat_front
   import rat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    fq_empty,
   output cls_type fq_item,
   input  logic    fq_pop
);

   cls_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   cls_type             cls;

   assign req_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign fq_empty = (count_ff == '0);
   assign fq_item  = q_ff[rd_ptr_ff];
   assign push     = req_push && !req_full;

   // Classify: 33-bit end for wrap and overlap tests, host minus base for lookup.
   always_comb begin
      cls.command    = req_data.command;
      cls.address    = req_data.address;
      cls.new_end    = {1'b0, req_data.address} + {1'b0, req_data.region_length};
      cls.host_delta = req_data.host_base - req_data.address;
      cls.new_type   = req_data.new_type;
   end

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = fq_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(fq_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/rat_back.sv
// ----------------------------------------------------------------------------
// Region address translator back end
// Holds the region table, runs add and translate, queues results.
// ----------------------------------------------------------------------------
module rat_back
   import rat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fq_empty,
   input  cls_type fq_item,
   output logic    fq_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic [31:0]        base_ff  [MAX_REGIONS];
   logic [32:0]        end_ff   [MAX_REGIONS];
   logic [31:0]        delta_ff [MAX_REGIONS];
   logic [3:0]         kind_ff  [MAX_REGIONS];
   logic [CNT_W-1:0]   entries_ff, entries_in;

   rsp_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               oq_full;
   logic               oq_pop;

   logic               table_full;
   logic               overlap;
   logic               hit;
   logic [31:0]        hit_delta;
   logic [3:0]         hit_kind;
   logic               do_write;
   rsp_type            result;

   assign oq_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign fq_pop    = !fq_empty && !oq_full;
   assign table_full = (entries_ff == CNT_W'(MAX_REGIONS));

   // Compare against every live entry in parallel; keep the first hit.
   always_comb begin
      overlap   = 1'b0;
      hit       = 1'b0;
      hit_delta = '0;
      hit_kind  = '0;
      for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
         if (CNT_W'(i) < entries_ff) begin
            if (({1'b0, fq_item.address} < end_ff[i]) &&
                (fq_item.new_end > {1'b0, base_ff[i]})) begin
               overlap = 1'b1;
            end
            if ((fq_item.address >= base_ff[i]) &&
                ({1'b0, fq_item.address} < end_ff[i])) begin
               hit       = 1'b1;
               hit_delta = delta_ff[i];
               hit_kind  = kind_ff[i];
            end
         end
      end
   end

   always_comb begin
      result   = '0;
      do_write = 1'b0;
      if (fq_item.command == CMD_TRANSLATE) begin
         if (hit) begin
            result.status       = ST_OK;
            result.host_address = fq_item.address + hit_delta;
            result.found_type   = hit_kind;
         end else begin
            result.status = ST_NOT_FOUND;
         end
      end else begin
         if (table_full) begin
            result.status = ST_FULL;
         end else if (fq_item.new_end[32]) begin
            result.status = ST_WRAPS;
         end else if (overlap) begin
            result.status = ST_OVERLAP;
         end else begin
            result.status = ST_OK;
            do_write      = fq_pop;
         end
      end
   end

   always_comb begin
      entries_in = do_write ? entries_ff + 1'b1 : entries_ff;
      wr_ptr_in  = fq_pop ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = oq_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + QCNT_W'(fq_pop) - QCNT_W'(oq_pop);
   end

   // Append at the slot after the last live entry.
   always_ff @(posedge clock) begin
      if (do_write) begin
         base_ff[entries_ff[IDX_W-1:0]]  <= fq_item.address;
         end_ff[entries_ff[IDX_W-1:0]]   <= fq_item.new_end;
         delta_ff[entries_ff[IDX_W-1:0]] <= fq_item.host_delta;
         kind_ff[entries_ff[IDX_W-1:0]]  <= fq_item.new_type;
      end
      if (fq_pop) begin
         q_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         entries_ff <= entries_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Region address translator testbench
// Sends add and translate items through the request queue, mirrors every
// accepted item in a local copy of the region table, and checks each reply
// field by field. Covers the empty table, region bounds, wrapping and
// overlapping adds, zero-length regions, a full table, random lookups and a
// long reply stall that backs the request side up.
// ----------------------------------------------------------------------------
module tb_top
   import rat_pkg::*;
();

   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int STALL_ITEMS    = 24;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int REPORT_LIMIT   = 10;

   typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_PATTERN, POP_RARELY} pop_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   req_type req_data  = '0;
   logic    rsp_pop   = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;

   // Local copy of the region table, updated as each item is accepted.
   logic [31:0] region_base [MAX_REGIONS];
   logic [31:0] region_len  [MAX_REGIONS];
   logic [31:0] region_host [MAX_REGIONS];
   logic [3:0]  region_kind [MAX_REGIONS];
   int          regions_used = 0;

   // Replies still owed by the block, oldest first.
   rsp_type awaited_replies [$];

   int reply_errors   = 0;
   int replies_seen   = 0;
   int items_sent     = 0;
   int add_outcomes [5];
   int lookups_hit    = 0;
   int lookups_missed = 0;
   int full_cycles    = 0;
   int quiet_cycles   = 0;

   // Sender burst control; steady_offer suppresses gaps entirely.
   int burst_left   = 0;
   bit steady_offer = 1'b0;

   // Long reply hold: the test bumps the request count, the receiver serves it.
   int hold_requests = 0;

   region_address_translator dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // -------------------------------------------------------------------------
   // Table predictor: apply one item to the local table, return its reply.
   // -------------------------------------------------------------------------
   function automatic rsp_type apply_to_table(input req_type item);
      rsp_type     reply;
      logic [32:0] new_end;
      logic [32:0] stored_end;
      bit          hit;
      reply = '0;
      hit   = 1'b0;
      if (item.command == CMD_ADD) begin
         new_end = {1'b0, item.address} + {1'b0, item.region_length};
         if (regions_used >= MAX_REGIONS) begin
            reply.status = ST_FULL;
         end else if (new_end > 33'h0_FFFF_FFFF) begin
            reply.status = ST_WRAPS;
         end else begin
            reply.status = ST_OK;
            // Half-open ranges: touching ends do not conflict.
            for (int i = 0; i < regions_used; i++) begin
               stored_end = {1'b0, region_base[i]} + {1'b0, region_len[i]};
               if ({1'b0, item.address} < stored_end && new_end > {1'b0, region_base[i]})
                  reply.status = ST_OVERLAP;
            end
            if (reply.status == ST_OK) begin
               region_base[regions_used] = item.address;
               region_len[regions_used]  = item.region_length;
               region_host[regions_used] = item.host_base;
               region_kind[regions_used] = item.new_type;
               regions_used++;
            end
         end
         add_outcomes[reply.status]++;
      end else begin
         reply.status = ST_NOT_FOUND;
         // First stored region that holds the address wins; empty ones never match.
         for (int i = 0; i < regions_used; i++) begin
            stored_end = {1'b0, region_base[i]} + {1'b0, region_len[i]};
            if (!hit && item.address >= region_base[i] && {1'b0, item.address} < stored_end) begin
               hit                = 1'b1;
               reply.status       = ST_OK;
               reply.host_address = region_host[i] + (item.address - region_base[i]);
               reply.found_type   = region_kind[i];
            end
         end
         if (hit) lookups_hit++;
         else     lookups_missed++;
      end
      return reply;
   endfunction

   function automatic req_type make_add(input logic [31:0] base, input logic [31:0] len,
                                        input logic [31:0] host, input logic [3:0] kind);
      req_type item;
      item.command       = CMD_ADD;
      item.address       = base;
      item.region_length = len;
      item.host_base     = host;
      item.new_type      = kind;
      return item;
   endfunction

   // Translate item; the add-only fields carry noise the block must ignore.
   function automatic req_type make_lookup(input logic [31:0] addr);
      req_type item;
      item.command       = CMD_TRANSLATE;
      item.address       = addr;
      item.region_length = $urandom;
      item.host_base     = $urandom;
      item.new_type      = 4'($urandom);
      return item;
   endfunction

   // Address at or around the edges of a stored region, or inside it.
   function automatic logic [31:0] near_region();
      int          k;
      logic [31:0] b;
      logic [31:0] n;
      if (regions_used == 0) return $urandom;
      k = $urandom_range(0, regions_used - 1);
      b = region_base[k];
      n = region_len[k];
      if (n == 0) return b;
      case ($urandom_range(0, 5))
         0: return b;
         1: return b + n - 1;
         2: return b + n;
         3: return b - 1;
         default: return b + ($urandom % n);
      endcase
   endfunction

   function automatic logic [31:0] random_length();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom_range(1, 256);
         2: return $urandom_range(1, 65536);
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Send one item: hold push until the queue takes it, then predict its reply.
   // Called at a rising edge; returns at the edge of acceptance or after a gap.
   // -------------------------------------------------------------------------
   task automatic offer_item(input req_type item);
      int gap;
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      awaited_replies.push_back(apply_to_table(item));
      items_sent++;
      if (!steady_offer) begin
         if (burst_left == 0) begin
            // End the burst: drop push for a random gap, pick the next burst size.
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
            gap        = $urandom_range(1, 8);
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver: pop on a pattern that changes mode now and then; honor long holds.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_pop
      static int           holds_served = 0;
      static int           hold_left    = 0;
      static int           mode_left    = 0;
      static pop_mode_type pop_mode     = POP_ALWAYS;
      static logic [4:0]   pop_pattern  = 5'b10110;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_requests != holds_served) begin
         // Start a long hold and count it down here.
         holds_served = hold_requests;
         hold_left    = LONG_HOLD;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            pop_mode  = pop_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         pop_pattern = {pop_pattern[3:0], pop_pattern[4]};
         case (pop_mode)
            POP_ALWAYS:  rsp_pop <= 1'b1;
            POP_MOSTLY:  rsp_pop <= ($urandom_range(0, 3) != 0);
            POP_PATTERN: rsp_pop <= pop_pattern[4];
            default:     rsp_pop <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Reply checker: compare each popped reply with the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_replies
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            if (reply_errors < REPORT_LIMIT)
               $display("%0t: reply with none expected: status %0d host %h type %h",
                        $realtime, rsp_data.status, rsp_data.host_address,
                        rsp_data.found_type);
            reply_errors++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_data.status !== want.status
                || rsp_data.host_address !== want.host_address
                || rsp_data.found_type !== want.found_type) begin
               if (reply_errors < REPORT_LIMIT)
                  $display("%0t: reply %0d mismatch: status %0d/%0d host %h/%h type %h/%h",
                           $realtime, replies_seen, want.status, rsp_data.status,
                           want.host_address, rsp_data.host_address,
                           want.found_type, rsp_data.found_type);
               reply_errors++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when neither side hands anything over for too long.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (req_push && req_full) full_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d replies outstanding",
                     quiet_cycles, awaited_replies.size());
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Lookups on an empty table miss at both ends of the address space.
   task automatic test_empty_table();
      offer_item(make_lookup(32'h0000_0000));
      offer_item(make_lookup(32'hFFFF_FFFF));
   endtask

   // First region, with a host base that wraps when the offset is added.
   task automatic test_add_and_translate();
      offer_item(make_add(32'h0000_0000, 32'h0000_0100, 32'hFFFF_FF80, 4'hF));
      offer_item(make_lookup(32'h0000_0000));
      offer_item(make_lookup(32'h0000_00FF));
      offer_item(make_lookup(32'h0000_0100));
   endtask

   // Region ending right at the top, one byte past it, maximum length, overlaps.
   task automatic test_region_bounds();
      offer_item(make_add(32'hFFFF_FF00, 32'h0000_00FF, 32'h0000_0000, 4'h0));
      offer_item(make_add(32'hFFFF_FF00, 32'h0000_0100, 32'h1111_1111, 4'h1));
      offer_item(make_add(32'h0000_0000, 32'hFFFF_FFFF, 32'h2222_2222, 4'h2));
      offer_item(make_lookup(32'hFFFF_FFFE));
      offer_item(make_lookup(32'hFFFF_FFFF));
      offer_item(make_add(32'h0000_0080, 32'h0000_0010, 32'h3333_3333, 4'h3));
   endtask

   // Empty regions: one inside a stored region, one stored, one straddled.
   task automatic test_zero_length();
      offer_item(make_add(32'h0000_0010, 32'h0000_0000, 32'h4444_4444, 4'h4));
      offer_item(make_add(32'h0000_1000, 32'h0000_0000, 32'h5555_5555, 4'h5));
      offer_item(make_add(32'h0000_0FF0, 32'h0000_0020, 32'h6666_6666, 4'h6));
      offer_item(make_add(32'h0000_1000, 32'h0000_0020, 32'h1234_5678, 4'hA));
      offer_item(make_lookup(32'h0000_1000));
   endtask

   // Fill the remaining slots, then add a region that is both too late and wraps.
   task automatic test_full_table();
      offer_item(make_add(32'h8000_0000, 32'h4000_0000, 32'hD000_0000, 4'h3));
      offer_item(make_add(32'h0000_2000, 32'h0000_0001, 32'hDEAD_BEEF, 4'h7));
      offer_item(make_add(32'h0001_0000, 32'h0001_0000, 32'h5555_0000, 4'hC));
      offer_item(make_add(32'hF000_0000, 32'h0F00_0000, 32'hAAAA_AAAA, 4'h9));
      offer_item(make_add(32'hFFFF_FFFF, 32'h0000_0002, 32'h7777_7777, 4'h8));
      offer_item(make_lookup(32'hBFFF_FFFF));
   endtask

   // Mostly lookups aimed at region edges, some random ones, some late adds.
   task automatic test_random_traffic();
      req_type item;
      repeat (RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1, 2:
               item = make_add(($urandom_range(0, 1) == 0) ? $urandom : near_region(),
                               random_length(), $urandom, 4'($urandom));
            3, 4, 5, 6:
               item = make_lookup($urandom);
            default:
               item = make_lookup(near_region());
         endcase
         offer_item(item);
      end
   endtask

   // Hold replies off for a long stretch while items keep coming back to back.
   task automatic test_reply_stall();
      steady_offer = 1'b1;
      hold_requests++;
      repeat (STALL_ITEMS) offer_item(make_lookup(near_region()));
      steady_offer = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 5; i++) add_outcomes[i] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_add_and_translate();
      test_region_bounds();
      test_zero_length();
      test_full_table();
      test_random_traffic();
      test_reply_stall();

      // Drop push, drain outstanding replies, then wait out the drain period.
      req_push <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d items, %0d replies checked, %0d reply errors",
               items_sent, replies_seen, reply_errors);
      $display("summary: adds ok %0d wrap %0d overlap %0d full %0d, lookups hit %0d miss %0d,"
               , add_outcomes[ST_OK], add_outcomes[ST_WRAPS], add_outcomes[ST_OVERLAP],
               add_outcomes[ST_FULL], lookups_hit, lookups_missed);
      $display("summary: request side held off by a full queue for %0d cycles", full_cycles);
      if (reply_errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
